@@ design/xde_pkg.sv @@
// shared types and constants for the xml entity decoder
`default_nettype none
package xde_pkg;

  localparam int EMIT_MAX = 6;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [20:0] MAX_CODE = 21'h10FFFF;

  typedef enum logic [2:0] {
    PH_PLAIN = 3'd0,
    PH_AMP   = 3'd1,
    PH_HASH  = 3'd2,
    PH_DEC   = 3'd3,
    PH_HEX   = 3'd4,
    PH_NAME  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    CAND_NONE = 3'd0,
    CAND_LT   = 3'd1,
    CAND_GT   = 3'd2,
    CAND_AMP  = 3'd3,
    CAND_APOS = 3'd4,
    CAND_QUOT = 3'd5,
    CAND_A    = 3'd6
  } cand_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // bytes produced by one item, in order, bytes[0] first
  typedef struct packed {
    logic [EMIT_MAX-1:0][7:0] bytes;
    logic [2:0]               cnt;
  } emit_t;

endpackage
`default_nettype wire

@@ design/xml_entity_decoder_top.sv @@
// top level of the xml character entity decoder
`default_nettype none
// Takes one byte of character data per cycle and returns the decoded bytes,
// 0 to 6 per item, with out_last on the last byte that an item causes.
// The decoder accepts one item every cycle as long as its 4-entry record
// queue has room; each output byte passes through the result register,
// so an item that expands to n bytes occupies the output side until all n
// are popped, and the queue absorbs short bursts of such expansions. With
// the queue and the result register idle, an accepted item's record is
// written into the queue and its first byte then loads the result register.
module xml_entity_decoder_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  input  wire xde_pkg::in_item_t  in_item,
  output logic                    in_full,
  output logic                    out_empty,
  output xde_pkg::out_item_t      out_item,
  input  wire logic               out_pop
);

  logic           rec_wr;
  xde_pkg::emit_t rec_wdata;
  logic           rec_full;
  logic           rec_rd;
  logic           rec_empty;
  xde_pkg::emit_t rec_rdata;

  assign in_full = rec_full;

  xde_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (rec_full),
    .rec_wr   (rec_wr),
    .rec_data (rec_wdata)
  );

  xde_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (rec_wr),
    .wr_data (rec_wdata),
    .full    (rec_full),
    .rd      (rec_rd),
    .empty   (rec_empty),
    .rd_data (rec_rdata)
  );

  xde_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_empty (rec_empty),
    .rec_data  (rec_rdata),
    .rec_rd    (rec_rd),
    .out_empty (out_empty),
    .out_item  (out_item),
    .out_pop   (out_pop)
  );

endmodule
`default_nettype wire

@@ design/xde_front.sv @@
// front end: entity state machine, turns each item into a record of output bytes
`default_nettype none
module xde_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire xde_pkg::in_item_t in_item,
  input  wire logic              in_full,
  output logic                   rec_wr,
  output xde_pkg::emit_t         rec_data
);

  function automatic xde_pkg::emit_t emit_put(xde_pkg::emit_t e, logic [7:0] b);
    xde_pkg::emit_t r;
    r = e;
    if (e.cnt < 3'(xde_pkg::EMIT_MAX)) begin
      r.bytes[e.cnt] = b;
      r.cnt = e.cnt + 3'd1;
    end
    return r;
  endfunction

  function automatic xde_pkg::emit_t emit_utf8(xde_pkg::emit_t e, logic [20:0] cp);
    xde_pkg::emit_t r;
    r = e;
    if (cp < 21'h80) begin
      r = emit_put(r, cp[7:0]);
    end else if (cp < 21'h800) begin
      r = emit_put(r, {3'b110, cp[10:6]});
      r = emit_put(r, {2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      r = emit_put(r, {4'b1110, cp[15:12]});
      r = emit_put(r, {2'b10, cp[11:6]});
      r = emit_put(r, {2'b10, cp[5:0]});
    end else begin
      r = emit_put(r, {5'b11110, cp[20:18]});
      r = emit_put(r, {2'b10, cp[17:12]});
      r = emit_put(r, {2'b10, cp[11:6]});
      r = emit_put(r, {2'b10, cp[5:0]});
    end
    return r;
  endfunction

  function automatic logic [7:0] name_char(xde_pkg::cand_t cand, logic [2:0] i);
    logic [39:0] txt;
    txt = '0;
    unique case (cand)
      xde_pkg::CAND_LT:   txt = {8'h00, 8'h00, ";", "t", "l"};
      xde_pkg::CAND_GT:   txt = {8'h00, 8'h00, ";", "t", "g"};
      xde_pkg::CAND_AMP:  txt = {8'h00, ";", "p", "m", "a"};
      xde_pkg::CAND_APOS: txt = {";", "s", "o", "p", "a"};
      xde_pkg::CAND_QUOT: txt = {";", "t", "o", "u", "q"};
      xde_pkg::CAND_A:    txt = {8'h00, 8'h00, 8'h00, 8'h00, "a"};
      default:            txt = '0;
    endcase
    if (i < 3'd5) begin
      return txt[{i, 3'b000} +: 8];
    end
    return 8'h00;
  endfunction

  function automatic logic [7:0] name_value(xde_pkg::cand_t cand);
    logic [7:0] v;
    unique case (cand)
      xde_pkg::CAND_LT:   v = "<";
      xde_pkg::CAND_GT:   v = ">";
      xde_pkg::CAND_AMP:  v = "&";
      xde_pkg::CAND_APOS: v = "'";
      xde_pkg::CAND_QUOT: v = "\"";
      default:            v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic xde_pkg::emit_t name_fail(xde_pkg::emit_t e, xde_pkg::cand_t cand,
                                               logic [2:0] lm);
    xde_pkg::emit_t r;
    r = emit_put(e, "&");
    for (int i = 0; i < 5; i++) begin
      if (3'(i) < lm) begin
        r = emit_put(r, name_char(cand, 3'(i)));
      end
    end
    return r;
  endfunction

  function automatic logic [20:0] sat_code(logic [24:0] v);
    return (v > {4'b0, xde_pkg::MAX_CODE}) ? xde_pkg::MAX_CODE : v[20:0];
  endfunction

  xde_pkg::phase_t ph_r, ph_nxt;
  xde_pkg::cand_t  cand_r, cand_nxt;
  logic [2:0]      lm_r, lm_nxt;
  logic [20:0]     cv_r, cv_nxt;

  logic            accept;
  logic [7:0]      c;
  logic            is_dec;
  logic            is_hex;
  logic [3:0]      hdig;
  logic [24:0]     cv_ext;
  logic [24:0]     dec_acc;
  logic [24:0]     hex_acc;
  logic            text_c;
  xde_pkg::emit_t  e;

  assign accept = in_push && !in_full;
  assign c      = in_item.in_byte;
  assign is_dec = (c >= "0") && (c <= "9");
  assign cv_ext = {4'b0, cv_r};

  always_comb begin
    is_hex = 1'b1;
    hdig   = 4'd0;
    if (is_dec) begin
      hdig = 4'(c - "0");
    end else if ((c >= "a") && (c <= "f")) begin
      hdig = 4'(c - "a" + 8'd10);
    end else if ((c >= "A") && (c <= "F")) begin
      hdig = 4'(c - "A" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign dec_acc = (cv_ext << 3) + (cv_ext << 1) + {21'b0, hdig};
  assign hex_acc = (cv_ext << 4) + {21'b0, hdig};

  always_comb begin
    ph_nxt   = ph_r;
    cand_nxt = cand_r;
    lm_nxt   = lm_r;
    cv_nxt   = cv_r;
    text_c   = 1'b0;
    e        = '0;

    unique case (ph_r)
      xde_pkg::PH_AMP: begin
        if (c == "#") begin
          ph_nxt = xde_pkg::PH_HASH;
          cv_nxt = '0;
        end else if (c == "l" || c == "g" || c == "a" || c == "q") begin
          ph_nxt = xde_pkg::PH_NAME;
          lm_nxt = 3'd1;
          priority case (c)
            "l":     cand_nxt = xde_pkg::CAND_LT;
            "g":     cand_nxt = xde_pkg::CAND_GT;
            "a":     cand_nxt = xde_pkg::CAND_A;
            default: cand_nxt = xde_pkg::CAND_QUOT;
          endcase
        end else begin
          e      = emit_put(e, "&");
          text_c = 1'b1;
        end
      end
      xde_pkg::PH_HASH, xde_pkg::PH_DEC: begin
        if (ph_r == xde_pkg::PH_HASH && (c == "x" || c == "X")) begin
          ph_nxt = xde_pkg::PH_HEX;
        end else if (is_dec) begin
          ph_nxt = xde_pkg::PH_DEC;
          cv_nxt = sat_code(dec_acc);
        end else begin
          e = emit_utf8(e, cv_r);
          if (c == ";") begin
            ph_nxt   = xde_pkg::PH_PLAIN;
            cand_nxt = xde_pkg::CAND_NONE;
            lm_nxt   = '0;
            cv_nxt   = '0;
          end else begin
            text_c = 1'b1;
          end
        end
      end
      xde_pkg::PH_HEX: begin
        if (is_hex) begin
          cv_nxt = sat_code(hex_acc);
        end else begin
          e = emit_utf8(e, cv_r);
          if (c == ";") begin
            ph_nxt   = xde_pkg::PH_PLAIN;
            cand_nxt = xde_pkg::CAND_NONE;
            lm_nxt   = '0;
            cv_nxt   = '0;
          end else begin
            text_c = 1'b1;
          end
        end
      end
      xde_pkg::PH_NAME: begin
        if (cand_r == xde_pkg::CAND_A && (c == "m" || c == "p")) begin
          cand_nxt = (c == "m") ? xde_pkg::CAND_AMP : xde_pkg::CAND_APOS;
          lm_nxt   = 3'd2;
        end else if (cand_r != xde_pkg::CAND_A && cand_r != xde_pkg::CAND_NONE &&
                     lm_r < 3'd5 && c == name_char(cand_r, lm_r)) begin
          if (c == ";") begin
            e        = emit_put(e, name_value(cand_r));
            ph_nxt   = xde_pkg::PH_PLAIN;
            cand_nxt = xde_pkg::CAND_NONE;
            lm_nxt   = '0;
            cv_nxt   = '0;
          end else begin
            lm_nxt = lm_r + 3'd1;
          end
        end else begin
          e      = name_fail(e, cand_r, lm_r);
          text_c = 1'b1;
        end
      end
      default: begin
        text_c = 1'b1;
      end
    endcase

    // current byte handled as plain text
    if (text_c) begin
      ph_nxt   = xde_pkg::PH_PLAIN;
      cand_nxt = xde_pkg::CAND_NONE;
      lm_nxt   = '0;
      cv_nxt   = '0;
      if (c == "&") begin
        ph_nxt = xde_pkg::PH_AMP;
      end else begin
        e = emit_put(e, c);
      end
    end

    // flush at end of run
    if (in_item.in_last) begin
      unique case (ph_nxt)
        xde_pkg::PH_AMP:                                    e = emit_put(e, "&");
        xde_pkg::PH_HASH, xde_pkg::PH_DEC, xde_pkg::PH_HEX: e = emit_utf8(e, cv_nxt);
        xde_pkg::PH_NAME:                                   e = name_fail(e, cand_nxt, lm_nxt);
        default:                                            ;
      endcase
      ph_nxt   = xde_pkg::PH_PLAIN;
      cand_nxt = xde_pkg::CAND_NONE;
      lm_nxt   = '0;
      cv_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= xde_pkg::PH_PLAIN;
      cand_r <= xde_pkg::CAND_NONE;
      lm_r   <= '0;
      cv_r   <= '0;
    end else if (accept) begin
      ph_r   <= ph_nxt;
      cand_r <= cand_nxt;
      lm_r   <= lm_nxt;
      cv_r   <= cv_nxt;
    end
  end

  // items with no output bytes leave no record
  assign rec_wr   = accept && (e.cnt != 3'd0);
  assign rec_data = e;

  a_rec_count: assert property (@(posedge clk) disable iff (!rst_n)
    rec_wr |-> (rec_data.cnt != 3'd0 && rec_data.cnt <= 3'(xde_pkg::EMIT_MAX)))
    else $error("record byte count out of range");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.in_last) |=> (ph_r == xde_pkg::PH_PLAIN && cv_r == '0))
    else $error("entity state not cleared after last item");

endmodule
`default_nettype wire

@@ design/xde_fifo.sv @@
// short record queue between front end and output stage
`default_nettype none
module xde_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr,
  input  wire xde_pkg::emit_t wr_data,
  output logic                full,
  input  wire logic           rd,
  output logic                empty,
  output xde_pkg::emit_t      rd_data
);

  xde_pkg::emit_t                 mem_r [xde_pkg::QDEPTH];
  logic [xde_pkg::QPTR_W-1:0]     wp_r, wp_nxt;
  logic [xde_pkg::QPTR_W-1:0]     rp_r, rp_nxt;
  logic [xde_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           do_wr;
  logic                           do_rd;

  assign full    = (cnt_r == xde_pkg::QCNT_W'(xde_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= xde_pkg::QCNT_W'(xde_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != xde_pkg::QCNT_W'(xde_pkg::QDEPTH)) |->
      (xde_pkg::QPTR_W'(wp_r - rp_r) == cnt_r[xde_pkg::QPTR_W-1:0]))
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

@@ design/xde_back.sv @@
// output stage: walks the bytes of each record into the result register
`default_nettype none
module xde_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           rec_empty,
  input  wire xde_pkg::emit_t rec_data,
  output logic                rec_rd,
  output logic                out_empty,
  output xde_pkg::out_item_t  out_item,
  input  wire logic           out_pop
);

  logic [2:0]         idx_r, idx_nxt;
  logic               vld_r, vld_nxt;
  xde_pkg::out_item_t item_r, item_nxt;
  logic               load;
  logic               at_end;

  assign load   = !rec_empty && (!vld_r || out_pop);
  assign at_end = (idx_r == rec_data.cnt - 3'd1);
  assign rec_rd = load && at_end;

  always_comb begin
    idx_nxt  = idx_r;
    vld_nxt  = vld_r;
    item_nxt = item_r;
    if (load) begin
      vld_nxt           = 1'b1;
      item_nxt.out_byte = rec_data.bytes[idx_r];
      item_nxt.out_last = at_end;
      idx_nxt           = at_end ? 3'd0 : idx_r + 3'd1;
    end else if (out_pop) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_empty = !vld_r;
  assign out_item  = item_r;

  a_idx_in_record: assert property (@(posedge clk) disable iff (!rst_n)
    !rec_empty |-> (idx_r < rec_data.cnt))
    else $error("byte index past end of record");

endmodule
`default_nettype wire

@@ sim/tb_xml_entity_decoder_top.sv @@
// self-checking testbench for the xml entity decoder with a byte-level decode predictor
module tb_xml_entity_decoder_top;

  class entity_scoreboard;
    xde_pkg::phase_t    phase;
    xde_pkg::cand_t     cand;
    logic [2:0]         letters;
    logic [20:0]        code;
    logic [7:0]         emit_q[$];
    xde_pkg::out_item_t decoded_q[$];
    int                 errors;
    int                 items_in;
    int                 bytes_out;

    function new();
      clear_entity();
      errors = 0;
      items_in = 0;
      bytes_out = 0;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function void clear_entity();
      phase = xde_pkg::PH_PLAIN;
      cand = xde_pkg::CAND_NONE;
      letters = '0;
      code = '0;
    endfunction

    function void put(logic [7:0] b);
      if (emit_q.size() < 8) emit_q.push_back(b);
    endfunction

    function void put_utf8(logic [20:0] cp);
      if (cp < 21'h80) begin
        put(cp[7:0]);
      end else if (cp < 21'h800) begin
        put(8'hC0 | 8'(cp >> 6));
        put(8'h80 | {2'b00, cp[5:0]});
      end else if (cp < 21'h10000) begin
        put(8'hE0 | 8'(cp >> 12));
        put(8'h80 | {2'b00, cp[11:6]});
        put(8'h80 | {2'b00, cp[5:0]});
      end else begin
        put(8'hF0 | 8'(cp >> 18));
        put(8'h80 | {2'b00, cp[17:12]});
        put(8'h80 | {2'b00, cp[11:6]});
        put(8'h80 | {2'b00, cp[5:0]});
      end
    endfunction

    function string name_tail(xde_pkg::cand_t c);
      case (c)
        xde_pkg::CAND_LT:   return "lt;";
        xde_pkg::CAND_GT:   return "gt;";
        xde_pkg::CAND_AMP:  return "amp;";
        xde_pkg::CAND_APOS: return "apos;";
        xde_pkg::CAND_QUOT: return "quot;";
        xde_pkg::CAND_A:    return "a";
        default:            return "";
      endcase
    endfunction

    function logic [7:0] name_char(xde_pkg::cand_t c, int idx);
      string s;
      s = name_tail(c);
      return (idx < s.len()) ? s[idx] : 8'h00;
    endfunction

    function logic [7:0] name_value(xde_pkg::cand_t c);
      case (c)
        xde_pkg::CAND_LT:   return "<";
        xde_pkg::CAND_GT:   return ">";
        xde_pkg::CAND_AMP:  return "&";
        xde_pkg::CAND_APOS: return "'";
        xde_pkg::CAND_QUOT: return "\"";
        default:            return 8'h00;
      endcase
    endfunction

    function int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function void accumulate(int unsigned base, int unsigned dg);
      int unsigned v;
      v = code * base + dg;
      code = (v > xde_pkg::MAX_CODE) ? xde_pkg::MAX_CODE : v[20:0];
    endfunction

    function void as_text(logic [7:0] c);
      clear_entity();
      if (c == "&") phase = xde_pkg::PH_AMP;
      else put(c);
    endfunction

    function void name_failed();
      int n;
      n = (letters > 5) ? 5 : letters;
      put("&");
      for (int i = 0; i < n; i++) put(name_char(cand, i));
    endfunction

    function void numeric_end(logic [7:0] c);
      put_utf8(code);
      if (c == ";") clear_entity();
      else as_text(c);
    endfunction

    function void decode_byte(logic [7:0] c);
      int d;
      case (phase)
        xde_pkg::PH_AMP: begin
          if (c == "#") begin
            phase = xde_pkg::PH_HASH;
            code = '0;
          end else begin
            cand = (c == "l") ? xde_pkg::CAND_LT : (c == "g") ? xde_pkg::CAND_GT :
                   (c == "a") ? xde_pkg::CAND_A : (c == "q") ? xde_pkg::CAND_QUOT :
                   xde_pkg::CAND_NONE;
            if (cand != xde_pkg::CAND_NONE) begin
              phase = xde_pkg::PH_NAME;
              letters = 3'd1;
            end else begin
              put("&");
              as_text(c);
            end
          end
        end
        xde_pkg::PH_HASH, xde_pkg::PH_DEC: begin
          if (phase == xde_pkg::PH_HASH && (c == "x" || c == "X")) begin
            phase = xde_pkg::PH_HEX;
          end else if (c >= "0" && c <= "9") begin
            phase = xde_pkg::PH_DEC;
            accumulate(10, c - "0");
          end else begin
            numeric_end(c);
          end
        end
        xde_pkg::PH_HEX: begin
          d = hex_value(c);
          if (d >= 0) accumulate(16, d);
          else numeric_end(c);
        end
        xde_pkg::PH_NAME: begin
          if (cand == xde_pkg::CAND_A && c == "m") begin
            cand = xde_pkg::CAND_AMP;
            letters = 3'd2;
          end else if (cand == xde_pkg::CAND_A && c == "p") begin
            cand = xde_pkg::CAND_APOS;
            letters = 3'd2;
          end else if (cand != xde_pkg::CAND_A && cand != xde_pkg::CAND_NONE &&
                       letters < 5 && c == name_char(cand, letters)) begin
            if (c == ";") begin
              put(name_value(cand));
              clear_entity();
            end else begin
              letters++;
            end
          end else begin
            name_failed();
            as_text(c);
          end
        end
        default: as_text(c);
      endcase
    endfunction

    function void flush_entity();
      case (phase)
        xde_pkg::PH_AMP:                                    put("&");
        xde_pkg::PH_HASH, xde_pkg::PH_DEC, xde_pkg::PH_HEX: put_utf8(code);
        xde_pkg::PH_NAME:                                   name_failed();
        default: ;
      endcase
      clear_entity();
    endfunction

    function void note_input(xde_pkg::in_item_t it);
      int n;
      xde_pkg::out_item_t r;
      emit_q.delete();
      decode_byte(it.in_byte);
      if (it.in_last) flush_entity();
      n = (emit_q.size() > xde_pkg::EMIT_MAX) ? xde_pkg::EMIT_MAX : emit_q.size();
      for (int k = 0; k < n; k++) begin
        r.out_byte = emit_q[k];
        r.out_last = (k == n - 1);
        decoded_q.push_back(r);
      end
      items_in++;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(xde_pkg::out_item_t got);
      xde_pkg::out_item_t want;
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", got.out_byte, got.out_last));
      end else begin
        want = decoded_q.pop_front();
        if (got.out_byte !== want.out_byte)
          report($sformatf("byte %0d: got %02h want %02h", bytes_out, got.out_byte,
                           want.out_byte));
        if (got.out_last !== want.out_last)
          report($sformatf("byte %0d: last got %0b want %0b", bytes_out, got.out_last,
                           want.out_last));
      end
      bytes_out++;
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_push;
  xde_pkg::in_item_t  in_item;
  logic               in_full;
  logic               out_empty;
  xde_pkg::out_item_t out_item;
  logic               out_pop;

  entity_scoreboard sb;
  int in_idle_pct;
  int out_idle_pct;
  int items_sent;
  int hold_seq;
  int hold_seen;
  int hold_left;

  xml_entity_decoder_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_item  (out_item),
    .out_pop   (out_pop)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_item(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < in_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_item.in_byte = b;
    in_item.in_last = l;
    do @(posedge clk); while (in_full);
    sb.note_input(in_item);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit last_at_end);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], last_at_end && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] odd_byte();
    string pool;
    pool = "&#;ltgampoquosxX0aZ<";
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  task automatic send_reference();
    logic [7:0] tok[$];
    string nm;
    string hexd;
    int kind;
    int n;
    int pos;
    bit hex;
    kind = $urandom_range(99);
    hexd = "0123456789abcdefABCDEF";
    if (kind < 30) begin
      tok.push_back(8'($urandom_range(255)));
    end else if (kind < 60) begin
      case ($urandom_range(4))
        0: nm = "&lt;";
        1: nm = "&gt;";
        2: nm = "&amp;";
        3: nm = "&apos;";
        default: nm = "&quot;";
      endcase
      for (int i = 0; i < nm.len(); i++) tok.push_back(nm[i]);
      if ($urandom_range(3) == 0) begin
        // broken name: cut short and ended with an odd byte, or one character replaced
        pos = $urandom_range(1, tok.size() - 1);
        if ($urandom_range(1) == 0) begin
          while (tok.size() > pos) void'(tok.pop_back());
          tok.push_back(odd_byte());
        end else begin
          tok[pos] = odd_byte();
        end
      end
    end else if (kind < 90) begin
      hex = $urandom_range(1);
      tok.push_back("&");
      tok.push_back("#");
      if (hex) tok.push_back($urandom_range(1) ? "x" : "X");
      n = ($urandom_range(9) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
      for (int i = 0; i < n; i++)
        tok.push_back(hex ? hexd[$urandom_range(hexd.len() - 1)] :
                      8'("0" + $urandom_range(9)));
      case ($urandom_range(3))
        0, 1: tok.push_back(";");
        2: tok.push_back(odd_byte());
        default: ;
      endcase
    end else begin
      tok.push_back("&");
      tok.push_back(odd_byte());
    end
    foreach (tok[i]) send_item(tok[i], $urandom_range(99) < 6);
  endtask

  task automatic wait_drained();
    in_push = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    out_pop = 1'b0;
    hold_left = 0;
    hold_seen = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_left = 90;
        hold_seen = hold_seq;
      end
      if (hold_left > 0) begin
        out_pop = 1'b0;
        hold_left--;
      end else begin
        out_pop = ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) sb.check_result(out_item);
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    hold_seq = 0;
    items_sent = 0;
    in_idle_pct = 19;
    out_idle_pct = 55;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_text("<&#;&lt;", 1'b0);
    send_text("&apos&", 1'b1);
    send_text("&#xd800", 1'b1);
    send_text("&q", 1'b1);

    while (items_sent < 170) send_reference();

    // long output hold while plain text keeps coming
    hold_seq++;
    for (int i = 0; i < 20; i++) send_item(8'("a" + $urandom_range(25)), 1'b0);
    wait_drained();

    in_idle_pct = 55;
    out_idle_pct = 19;
    while (items_sent < 330) send_reference();

    in_idle_pct = 0;
    out_idle_pct = 0;
    while (items_sent < 480) send_reference();

    wait_drained();
    repeat (12) @(negedge clk);

    $display("decoded %0d input items into %0d output bytes", sb.items_in, sb.bytes_out);
    $display("named, numeric, broken and flushed references under stalls and a long hold");
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
